// ===== sv/vector_image_stream_decoder_top_assert.svh =====
// Assertion macros shared by the decoder RTL
`ifndef VECTOR_IMAGE_STREAM_DECODER_TOP_ASSERT_SVH
`define VECTOR_IMAGE_STREAM_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define VIS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define VIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/vis_pkg.sv =====
// Types, constants and helper functions of the vector image stream decoder
`default_nettype none
package vis_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [3:0] SCALE_RESET = 4'd5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [3:0] {
    PH_BG_LO,
    PH_BG_HI,
    PH_NCOL,
    PH_COL_LO,
    PH_COL_HI,
    PH_COUNT,
    PH_ITEMS
  } vis_phase_t;

  typedef enum logic [2:0] {
    KIND_BG,
    KIND_RECT,
    KIND_VLINE,
    KIND_HLINE,
    KIND_PIXEL,
    KIND_END
  } vis_kind_t;

  typedef enum logic [1:0] {
    LIST_RECT,
    LIST_VLINE,
    LIST_HLINE,
    LIST_PIXEL
  } vis_list_t;

  typedef struct packed {
    vis_kind_t        kind;
    logic [15:0]      color;
    logic [3:0][7:0]  bytes;
    logic             end_after;
  } vis_cmd_t;

  function automatic logic [2:0] item_len(vis_list_t k);
    logic [2:0] len;
    unique case (k)
      LIST_RECT:  len = 3'd4;
      LIST_VLINE: len = 3'd3;
      LIST_HLINE: len = 3'd3;
      LIST_PIXEL: len = 3'd2;
      default:    len = 3'd2;
    endcase
    return len;
  endfunction

  function automatic vis_kind_t list_kind(vis_list_t k);
    vis_kind_t kind;
    unique case (k)
      LIST_RECT:  kind = KIND_RECT;
      LIST_VLINE: kind = KIND_VLINE;
      LIST_HLINE: kind = KIND_HLINE;
      LIST_PIXEL: kind = KIND_PIXEL;
      default:    kind = KIND_PIXEL;
    endcase
    return kind;
  endfunction

  function automatic logic [3:0] eff_scale(logic [3:0] s);
    logic [3:0] e;
    priority if (s == 4'd0) e = 4'd1;
    else if (s > 4'd8) e = 4'd8;
    else e = s;
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== sv/vector_image_stream_decoder_top.sv =====
// Top level of the vector image stream decoder
//
// Input: one stream byte per transaction on in_data_byte, taken when push is
// high and full is low. The parser takes a byte in every cycle as long as its
// command queue has room, so the sustained rate is one byte per cycle.
// Output: one draw command per transaction, shown while empty is low and taken
// when pop is high. A command passes from the parser through the command queue
// into the result register before it is shown. A byte that ends the last
// list of an image yields its primitive, if any, and then the end marker;
// last marks the final command of a byte. The result register and the
// command generator deliver one command per cycle while pop takes each one;
// the single result register drains only through pop.
// When the receiver stalls, the result holds, the queue fills, and full rises
// once the queue is full; bytes that cause no command still need room to be
// taken. Configuration: scale_factor at byte address 0 over the APB-style
// port; the user must write it only while the block is idle, which the block
// does not enforce. Reset returns the parser to the background color,
// empties the queue and loads scale_factor with 5.
`default_nettype none
module vector_image_stream_decoder_top #(
  parameter int QUEUE_DEPTH = vis_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      in_data_byte,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [2:0]                           out_command_kind,
  output logic [15:0]                          out_fill_color,
  output logic [10:0]                          out_pos_x,
  output logic [10:0]                          out_pos_y,
  output logic [10:0]                          out_size_w,
  output logic [10:0]                          out_size_h,
  output logic                                 out_last,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [vis_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [vis_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [vis_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  logic [3:0]        scale_r, scale_nxt;
  logic              accept;
  logic              cmd_valid;
  vis_pkg::vis_cmd_t cmd;
  vis_pkg::vis_cmd_t q_cmd;
  logic              q_empty;
  logic              q_pop;
  logic              cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[vis_pkg::CFG_ADDR_W-1] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= vis_pkg::SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  always_comb begin
    scale_nxt = scale_r;
    if (psel && penable && pwrite && pready && cfg_hit) begin
      scale_nxt = pwdata[3:0];
    end
  end

  assign prdata = cfg_hit ? {{(vis_pkg::CFG_DATA_W - 4){1'b0}}, scale_r} : '0;
  assign accept = push && !full;

  vis_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .byte_i      (in_data_byte),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  vis_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (cmd_valid),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .empty_o (q_empty)
  );

  vis_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .scale_i        (vis_pkg::eff_scale(scale_r)),
    .q_cmd_i        (q_cmd),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .command_kind_o (out_command_kind),
    .fill_color_o   (out_fill_color),
    .pos_x_o        (out_pos_x),
    .pos_y_o        (out_pos_y),
    .size_w_o       (out_size_w),
    .size_h_o       (out_size_h),
    .last_o         (out_last)
  );

endmodule
`default_nettype wire

// ===== sv/vis_front.sv =====
// Byte parser: tracks the stream layout and classifies each byte into commands
`default_nettype none
module vis_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept_i,
  input  wire logic [7:0]       byte_i,
  output logic                  cmd_valid_o,
  output vis_pkg::vis_cmd_t     cmd_o
);
  `include "vector_image_stream_decoder_top_assert.svh"

  vis_pkg::vis_phase_t phase_r, phase_nxt;
  vis_pkg::vis_list_t  list_r, list_nxt;
  logic [1:0]          pos_r, pos_nxt;
  logic [7:0]          colors_r, colors_nxt;
  logic [15:0]         items_r, items_nxt;
  logic [15:0]         color_r, color_nxt;
  logic [3:0][7:0]     field_r, field_nxt;
  logic [3:0][7:0]     fb;
  logic                list_done;
  logic                end_flag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= vis_pkg::PH_BG_LO;
      list_r   <= vis_pkg::LIST_RECT;
      pos_r    <= 2'd0;
      colors_r <= 8'd0;
      items_r  <= 16'd0;
      color_r  <= 16'd0;
    end else begin
      phase_r  <= phase_nxt;
      list_r   <= list_nxt;
      pos_r    <= pos_nxt;
      colors_r <= colors_nxt;
      items_r  <= items_nxt;
      color_r  <= color_nxt;
    end
    field_r <= field_nxt;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fb[i] = (pos_r == 2'(i)) ? byte_i : field_r[i];
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    list_nxt    = list_r;
    pos_nxt     = pos_r;
    colors_nxt  = colors_r;
    items_nxt   = items_r;
    color_nxt   = color_r;
    field_nxt   = field_r;
    list_done   = 1'b0;
    end_flag    = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    if (accept_i) begin
      unique case (phase_r)
        vis_pkg::PH_BG_HI: begin
          color_nxt   = {byte_i, color_r[7:0]};
          phase_nxt   = vis_pkg::PH_NCOL;
          cmd_valid_o = 1'b1;
          cmd_o.kind  = vis_pkg::KIND_BG;
          cmd_o.color = {byte_i, color_r[7:0]};
        end
        vis_pkg::PH_NCOL: begin
          colors_nxt = byte_i;
          if (byte_i == 8'd0) begin
            phase_nxt = vis_pkg::PH_BG_LO;
            end_flag  = 1'b1;
          end else begin
            phase_nxt = vis_pkg::PH_COL_LO;
          end
        end
        vis_pkg::PH_COL_LO: begin
          color_nxt = {8'h00, byte_i};
          phase_nxt = vis_pkg::PH_COL_HI;
        end
        vis_pkg::PH_COL_HI: begin
          color_nxt = {byte_i, color_r[7:0]};
          phase_nxt = vis_pkg::PH_COUNT;
          list_nxt  = vis_pkg::LIST_RECT;
          pos_nxt   = 2'd0;
        end
        vis_pkg::PH_COUNT: begin
          if (pos_r == 2'd0) begin
            items_nxt = {8'h00, byte_i};
            pos_nxt   = 2'd1;
          end else begin
            items_nxt = {byte_i, items_r[7:0]};
            pos_nxt   = 2'd0;
            if ({byte_i, items_r[7:0]} != 16'd0) begin
              phase_nxt = vis_pkg::PH_ITEMS;
            end else begin
              list_done = 1'b1;
            end
          end
        end
        vis_pkg::PH_ITEMS: begin
          field_nxt[pos_r] = byte_i;
          if (({1'b0, pos_r} + 3'd1) < vis_pkg::item_len(list_r)) begin
            pos_nxt = pos_r + 2'd1;
          end else begin
            pos_nxt     = 2'd0;
            cmd_valid_o = 1'b1;
            cmd_o.kind  = vis_pkg::list_kind(list_r);
            cmd_o.color = color_r;
            cmd_o.bytes = fb;
            items_nxt   = items_r - 16'd1;
            if (items_r == 16'd1) begin
              list_done = 1'b1;
            end
          end
        end
        default: begin
          color_nxt = {8'h00, byte_i};
          phase_nxt = vis_pkg::PH_BG_HI;
          pos_nxt   = 2'd0;
        end
      endcase

      if (list_done) begin
        pos_nxt = 2'd0;
        if (list_r != vis_pkg::LIST_PIXEL) begin
          list_nxt  = vis_pkg::vis_list_t'(list_r + 2'd1);
          phase_nxt = vis_pkg::PH_COUNT;
        end else begin
          colors_nxt = colors_r - 8'd1;
          if (colors_r == 8'd1) begin
            phase_nxt = vis_pkg::PH_BG_LO;
            end_flag  = 1'b1;
          end else begin
            phase_nxt = vis_pkg::PH_COL_LO;
          end
        end
      end

      if (end_flag) begin
        if (cmd_valid_o) begin
          cmd_o.end_after = 1'b1;
        end else begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = vis_pkg::KIND_END;
        end
      end
    end
  end

  `VIS_ASSERT(a_items_nonzero, clk, rst_n, (phase_r == vis_pkg::PH_ITEMS) |-> (items_r != 16'd0), "item phase with empty list")

endmodule
`default_nettype wire

// ===== sv/vis_queue.sv =====
// Command queue between the parser and the command generator
`default_nettype none
module vis_queue #(
  parameter int DEPTH = vis_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_i,
  input  wire vis_pkg::vis_cmd_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output vis_pkg::vis_cmd_t      data_o,
  output logic                   empty_o
);
  `include "vector_image_stream_decoder_top_assert.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  vis_pkg::vis_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  assign data_o  = mem_r[rd_ptr_r];
  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == CNT_W'(DEPTH));

  `VIS_ASSERT(a_no_underflow, clk, rst_n, pop_i |-> (count_r != '0), "pop from empty queue")
  `VIS_ASSERT(a_no_overflow, clk, rst_n, push_i |-> (count_r != CNT_W'(DEPTH)), "push to full queue")

endmodule
`default_nettype wire

// ===== sv/vis_back.sv =====
// Command generator: scales queued commands and holds the result register
`default_nettype none
module vis_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [3:0]        scale_i,
  input  wire vis_pkg::vis_cmd_t q_cmd_i,
  input  wire logic              q_empty_i,
  output logic                   q_pop_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic [2:0]             command_kind_o,
  output logic [15:0]            fill_color_o,
  output logic [10:0]            pos_x_o,
  output logic [10:0]            pos_y_o,
  output logic [10:0]            size_w_o,
  output logic [10:0]            size_h_o,
  output logic                   last_o
);
  `include "vector_image_stream_decoder_top_assert.svh"

  logic                 valid_r, valid_nxt;
  logic                 pend_end_r, pend_end_nxt;
  vis_pkg::vis_kind_t   kind_r, kind_nxt;
  logic [15:0]          color_r, color_nxt;
  logic [10:0]          x_r, x_nxt;
  logic [10:0]          y_r, y_nxt;
  logic [10:0]          w_r, w_nxt;
  logic [10:0]          h_r, h_nxt;
  logic                 last_r, last_nxt;
  logic [11:0]          prod [4];
  logic [10:0]          s_ext;
  logic                 load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      pend_end_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      pend_end_r <= pend_end_nxt;
    end
    kind_r  <= kind_nxt;
    color_r <= color_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    last_r  <= last_nxt;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = {4'd0, q_cmd_i.bytes[i]} * {8'd0, scale_i};
    end
  end

  assign s_ext = {7'd0, scale_i};
  assign load  = !valid_r || pop_i;

  always_comb begin
    valid_nxt    = valid_r;
    pend_end_nxt = pend_end_r;
    kind_nxt     = kind_r;
    color_nxt    = color_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    w_nxt        = w_r;
    h_nxt        = h_r;
    last_nxt     = last_r;
    q_pop_o      = 1'b0;
    if (load) begin
      priority if (pend_end_r) begin
        valid_nxt    = 1'b1;
        pend_end_nxt = 1'b0;
        kind_nxt     = vis_pkg::KIND_END;
        color_nxt    = 16'd0;
        x_nxt        = 11'd0;
        y_nxt        = 11'd0;
        w_nxt        = 11'd0;
        h_nxt        = 11'd0;
        last_nxt     = 1'b1;
      end else if (!q_empty_i) begin
        q_pop_o      = 1'b1;
        valid_nxt    = 1'b1;
        pend_end_nxt = q_cmd_i.end_after;
        kind_nxt     = q_cmd_i.kind;
        color_nxt    = q_cmd_i.color;
        x_nxt        = prod[0][10:0];
        y_nxt        = prod[1][10:0];
        last_nxt     = !q_cmd_i.end_after;
        unique case (q_cmd_i.kind)
          vis_pkg::KIND_RECT: begin
            w_nxt = prod[2][10:0];
            h_nxt = prod[3][10:0];
          end
          vis_pkg::KIND_VLINE: begin
            w_nxt = s_ext;
            h_nxt = prod[2][10:0];
          end
          vis_pkg::KIND_HLINE: begin
            w_nxt = prod[2][10:0];
            h_nxt = s_ext;
          end
          vis_pkg::KIND_PIXEL: begin
            w_nxt = s_ext;
            h_nxt = s_ext;
          end
          default: begin
            w_nxt = 11'd0;
            h_nxt = 11'd0;
          end
        endcase
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  assign empty_o        = !valid_r;
  assign command_kind_o = kind_r;
  assign fill_color_o   = color_r;
  assign pos_x_o        = x_r;
  assign pos_y_o        = y_r;
  assign size_w_o       = w_r;
  assign size_h_o       = h_r;
  assign last_o         = last_r;

  `VIS_ASSERT(a_pend_shown, clk, rst_n, pend_end_r |-> valid_r, "end marker pending without a shown result")
  `VIS_ASSERT_NEXT(a_end_follows, clk, rst_n, valid_r && !last_r && pop_i, valid_r && (kind_r == vis_pkg::KIND_END) && last_r, "end marker did not follow")

endmodule
`default_nettype wire
